// ----- design/bmtc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bmtc_pkg;

  localparam int ROW_W = 64;
  localparam int BIT_W = $clog2(ROW_W);
  localparam int IDX_W = 7;
  localparam int OUT_IDX_W = 6;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CLOSE,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_LOAD,
    OP_CLOSE,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [IDX_W-1:0]   sel_idx;
    logic [IDX_W-1:0]   last_idx;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- design/bmtc_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface bmtc_row_if import bmtc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_bits;

  modport source (output valid, output row_bits, input ready);
  modport sink (input valid, input row_bits, output ready);
endinterface

interface bmtc_res_if import bmtc_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_IDX_W-1:0] row_index;
  logic [ROW_W-1:0]     closure_bits;
  logic                 last_row;

  modport source (output valid, output row_index, output closure_bits, output last_row,
                  input ready);
  modport sink (input valid, input row_index, input closure_bits, input last_row,
                output ready);
endinterface

`default_nettype wire

// ----- design/bit_matrix_transitive_closure.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Reflexive-transitive closure of a directed graph held as a bit matrix.
// rows   : sink channel, one adjacency row per transaction, row 0 first;
//          bit j of row i is an edge from i to j. Bits at or above the vertex
//          count are masked on entry.
// result : source channel, one closure row per transaction in index order,
//          last_row high on the final row of the matrix.
// cfg_we / cfg_wdata : write the vertex count (0 reads as 1, above
//          MAX_VERTICES saturates). A write drops any partly loaded matrix.
// Timing: n rows are taken one per cycle while rows.valid is high, then a
// closure pass over n pivots (one pivot per cycle, each pivot rotating the
// whole chain of row cells by one place), then n result transactions, one
// per cycle while result.ready is high. rows.ready is low from the last
// row until the final result transaction.
// A stalled receiver freezes the chain; the result payload holds.
// Reset (rst, synchronous) returns to loading with no rows held and a
// vertex count of 64; row storage is not cleared, every row is loaded before
// it is read.

module bit_matrix_transitive_closure import bmtc_pkg::*; #(
  parameter int MAX_VERTICES = 64
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [IDX_W-1:0] cfg_wdata,
  bmtc_row_if.sink              rows,
  bmtc_res_if.source            result
);

  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  logic [IDX_W-1:0] vertex_count;
  logic [IDX_W-1:0] n_active;
  logic [ROW_W-1:0] width_mask;
  logic [ROW_W-1:0] load_row;
  logic [ROW_W-1:0] cell_row [MAX_VERTICES];
  cell_ctrl_t       cell_ctrl;

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= IDX_W'(64);
    end else if (cfg_we) begin
      vertex_count <= cfg_wdata;
    end
  end

  // clamp the count to the built chain length
  always_comb begin
    if (vertex_count == '0) begin
      n_active = IDX_W'(1);
    end else if (vertex_count > IDX_W'(MAX_VERTICES)) begin
      n_active = IDX_W'(MAX_VERTICES);
    end else begin
      n_active = vertex_count;
    end
  end

  always_comb begin
    for (int j = 0; j < ROW_W; j++) begin
      width_mask[j] = (IDX_W'(j) < n_active);
    end
  end

  assign load_row = rows.row_bits & width_mask;

  bmtc_ctrl #(
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .n_active  (n_active),
    .in_valid  (rows.valid),
    .out_ready (result.ready),
    .in_ready  (rows.ready),
    .out_valid (result.valid),
    .row_index (result.row_index),
    .last_row  (result.last_row),
    .cell_ctrl (cell_ctrl)
  );

  // Chain of row cells: cell 0 is the head and holds the current pivot during
  // the closure pass (or the next row to emit); each cell takes its upper neighbour,
  // and the tail at n-1 takes the head back, so the ring closes at n.
  for (genvar g = 0; g < MAX_VERTICES; g++) begin : g_cell
    logic [ROW_W-1:0] neighbour;
    if (g == MAX_VERTICES - 1) begin : g_end
      assign neighbour = cell_row[0];
    end else begin : g_mid
      assign neighbour = cell_row[g+1];
    end

    bmtc_cell u_cell (
      .clk           (clk),
      .ctrl          (cell_ctrl),
      .cell_idx      (IDX_W'(g)),
      .load_row      (load_row),
      .head_row      (cell_row[0]),
      .neighbour_row (neighbour),
      .row           (cell_row[g])
    );
  end

  // the head cell is the result payload register
  assign result.closure_bits = cell_row[0];

endmodule

`default_nettype wire

// ----- design/bmtc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bmtc_cell import bmtc_pkg::*; (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [ROW_W-1:0] load_row,
  input  wire logic [ROW_W-1:0] head_row,
  input  wire logic [ROW_W-1:0] neighbour_row,
  output logic      [ROW_W-1:0] row
);

  logic [ROW_W-1:0] row_next;
  logic [BIT_W-1:0] pivot;
  logic             is_tail;

  assign pivot   = ctrl.sel_idx[BIT_W-1:0];
  assign is_tail = (cell_idx == ctrl.last_idx);

  always_comb begin
    row_next = row;
    case (ctrl.op)
      OP_LOAD: begin
        if (cell_idx == ctrl.sel_idx) begin
          row_next = load_row;
        end
      end
      OP_CLOSE: begin
        // tail takes the pivot row back with its diagonal bit set
        if (is_tail) begin
          row_next = head_row | (ROW_W'(1) << pivot);
        end else if (neighbour_row[pivot]) begin
          row_next = neighbour_row | head_row;
        end else begin
          row_next = neighbour_row;
        end
      end
      OP_SHIFT: begin
        row_next = is_tail ? head_row : neighbour_row;
      end
      default: begin
        row_next = row;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    row <= row_next;
  end

endmodule

`default_nettype wire

// ----- design/bmtc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module bmtc_ctrl import bmtc_pkg::*; #(
  parameter int CNT_W = 7
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [IDX_W-1:0]     n_active,
  input  wire logic                 in_valid,
  input  wire logic                 out_ready,
  output logic                      in_ready,
  output logic                      out_valid,
  output logic [OUT_IDX_W-1:0]      row_index,
  output logic                      last_row,
  output cell_ctrl_t                cell_ctrl
);

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] cnt_ext;
  logic             at_last;

  assign last_idx = n_active - IDX_W'(1);
  assign cnt_ext  = IDX_W'(cnt);
  assign at_last  = (cnt_ext == last_idx);

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_LOAD: begin
        if (in_valid) begin
          cnt_next = at_last ? '0 : cnt + CNT_W'(1);
          if (at_last) begin
            state_next = ST_CLOSE;
          end
        end
      end
      ST_CLOSE: begin
        cnt_next = at_last ? '0 : cnt + CNT_W'(1);
        if (at_last) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_ready) begin
          cnt_next = at_last ? '0 : cnt + CNT_W'(1);
          if (at_last) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
        cnt_next   = '0;
      end
    endcase
    // drop any partial matrix on a register write
    if (cfg_we) begin
      state_next = ST_LOAD;
      cnt_next   = '0;
    end
  end

  // outputs
  always_comb begin
    in_ready           = 1'b0;
    out_valid          = 1'b0;
    cell_ctrl.op       = OP_HOLD;
    cell_ctrl.sel_idx  = cnt_ext;
    cell_ctrl.last_idx = last_idx;
    case (state)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cell_ctrl.op = OP_LOAD;
        end
      end
      ST_CLOSE: begin
        cell_ctrl.op = OP_CLOSE;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cell_ctrl.op = OP_SHIFT;
        end
      end
      default: begin
        cell_ctrl.op = OP_HOLD;
      end
    endcase
  end

  assign row_index = OUT_IDX_W'(cnt);
  assign last_row  = at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt_ext < n_active)
    else $error("row counter beyond vertex count");

  a_close_flow: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLOSE && !cfg_we) |=> (state == ST_CLOSE || state == ST_EMIT))
    else $error("closure pass left early");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_row && !cfg_we) |=> in_ready)
    else $error("not ready for next matrix after last row");
`endif

endmodule

`default_nettype wire
